// ----- src/aarm_pkg.sv -----
// ----------------------------------------------------------------------------
// aarm_pkg: shared constants, tables and types
// CORDIC arctangent table, angle constants and the queue status type used by
// the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int SINCOS_STEPS_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int QUEUE_DEPTH       = 4;
   localparam int AXIS_W            = 16;
   localparam int ENTRY_W           = 16;
   localparam int CS_W              = 16;

   // arctangent of 2^-i, Q30, truncated
   localparam longint ATAN_Q30 [32] = '{
      64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
      64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
      64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
      64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
      64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F, 64'sh0000003F,
      64'sh0000001F, 64'sh0000000F, 64'sh00000007, 64'sh00000003, 64'sh00000001,
      64'sh0, 64'sh0
   };

   localparam longint GAIN_Q30    = 64'sh26DD3B6A;
   localparam longint HALF_PI_Q30 = 64'sh6487ED51;
   localparam longint PI_Q30      = 64'shC90FDAA2;

   // Q30 constant rounded half up to f fraction bits
   function automatic longint q30_to_f(input longint v, input int f);
      longint r;
      if (f >= 30) begin
         r = v;
      end else begin
         r = (v + (longint'(1) <<< (29 - f))) >>> (30 - f);
      end
      return r;
   endfunction

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ----- src/aarm_front.sv -----
// ----------------------------------------------------------------------------
// aarm_front: input stage
// Accepts a word, rescales the angle to the CORDIC format and folds it into
// plus or minus pi/2, flagging a sign flip of sine and cosine.
// ----------------------------------------------------------------------------
module aarm_front import aarm_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int ANGLE_W       = FRACTION_BITS_DEF + 4,
   parameter int WORD_W        = 1 + FRACTION_BITS_DEF + 4 + 3 * AXIS_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [15:0]       req_angle,
   input  logic signed [15:0]       req_axis_x,
   input  logic signed [15:0]       req_axis_y,
   input  logic signed [15:0]       req_axis_z,
   input  q_status_type             q_status,
   output logic                     push,
   output logic [WORD_W-1:0]        push_word
);

   localparam int TW   = ANGLE_W + 16;
   localparam int SH_L = (FRACTION_BITS >= 13) ? FRACTION_BITS - 13 : 0;
   localparam int SH_R = (FRACTION_BITS >= 13) ? 0 : 13 - FRACTION_BITS;
   localparam logic signed [TW-1:0] RND = (SH_R > 0) ? (TW'(1) << (SH_R - 1)) : '0;
   localparam logic signed [ANGLE_W-1:0] HP = ANGLE_W'(q30_to_f(HALF_PI_Q30, FRACTION_BITS));
   localparam logic signed [ANGLE_W-1:0] PI = ANGLE_W'(q30_to_f(PI_Q30, FRACTION_BITS));

   logic                      valid_ff;
   logic [WORD_W-1:0]         word_ff, word_in;
   logic                      take;
   logic signed [TW-1:0]      ang_ext;
   logic signed [TW-1:0]      ang_scaled;
   logic signed [ANGLE_W-1:0] z0, z_fold;
   logic                      neg;

   assign take      = !valid_ff || !q_status.full;
   assign req_stall = !take;
   assign push      = valid_ff && !q_status.full;
   assign push_word = word_ff;

   // rescale Q13 angle and fold into the CORDIC range
   always_comb begin
      ang_ext = {{(TW - 16){req_angle[15]}}, req_angle};
      if (SH_R > 0) begin
         ang_scaled = (ang_ext + RND) >>> SH_R;
      end else begin
         ang_scaled = ang_ext <<< SH_L;
      end
      z0 = ang_scaled[ANGLE_W-1:0];
      neg = 1'b0;
      z_fold = z0;
      if (z0 > HP) begin
         z_fold = z0 - PI;
         neg = 1'b1;
      end else if (z0 < -HP) begin
         z_fold = z0 + PI;
         neg = 1'b1;
      end
      word_in = {neg, z_fold, req_axis_x, req_axis_y, req_axis_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= req_valid;
      end
      if (take && req_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

// ----- src/aarm_queue.sv -----
// ----------------------------------------------------------------------------
// aarm_queue: decoupling queue
// Small register queue between the front stage and the CORDIC pipeline.
// ----------------------------------------------------------------------------
module aarm_queue import aarm_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_word,
   output q_status_type     status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == CW'(DEPTH));
   assign pop_word     = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("queue count out of range");
   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("queue count up");
   a_cnt_dn: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("queue count down");
`endif

endmodule

// ----- src/aarm_back.sv -----
// ----------------------------------------------------------------------------
// aarm_back: sine/cosine and matrix pipeline
// Pipelined CORDIC, one stage per step, then two multiply stages and a
// rounding and saturation stage that forms the output register.
// ----------------------------------------------------------------------------
module aarm_back import aarm_pkg::*; #(
   parameter int SINCOS_STEPS  = SINCOS_STEPS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int ANGLE_W       = FRACTION_BITS_DEF + 4,
   parameter int WORD_W        = 1 + FRACTION_BITS_DEF + 4 + 3 * AXIS_W
) (
   input  logic               clock,
   input  logic               reset,
   input  q_status_type       q_status,
   input  logic [WORD_W-1:0]  pop_word,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22
);

   localparam int S  = SINCOS_STEPS;
   localparam int W  = ANGLE_W;
   localparam int TW = W + 8;
   localparam int SH_R = (FRACTION_BITS >= 14) ? FRACTION_BITS - 14 : 0;
   localparam int SH_L = (FRACTION_BITS >= 14) ? 0 : 14 - FRACTION_BITS;
   localparam logic signed [TW-1:0] RND = (SH_R > 0) ? (TW'(1) << (SH_R - 1)) : '0;
   localparam logic signed [W-1:0] GAIN = W'(q30_to_f(GAIN_Q30, FRACTION_BITS));
   localparam int PW = 50;

   logic en;

   // CORDIC stage registers
   logic                 cv_ff  [S+1];
   logic signed [W-1:0]  x_ff   [S+1];
   logic signed [W-1:0]  y_ff   [S+1];
   logic signed [W-1:0]  z_ff   [S+1];
   logic                 neg_ff [S+1];
   logic signed [15:0]   ax_ff  [S+1];
   logic signed [15:0]   ay_ff  [S+1];
   logic signed [15:0]   az_ff  [S+1];

   assign en  = !rsp_valid || !rsp_stall;
   assign pop = en && !q_status.empty;

   // stage 0 loads from the queue, then one CORDIC step per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= S; i++) begin
            cv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         cv_ff[0] <= !q_status.empty;
         for (int i = 0; i < S; i++) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end
      if (pop) begin
         x_ff[0]   <= GAIN;
         y_ff[0]   <= '0;
         neg_ff[0] <= pop_word[WORD_W-1];
         z_ff[0]   <= pop_word[WORD_W-2 -: W];
         ax_ff[0]  <= pop_word[47:32];
         ay_ff[0]  <= pop_word[31:16];
         az_ff[0]  <= pop_word[15:0];
      end
      if (en) begin
         for (int i = 0; i < S; i++) begin
            if (!z_ff[i][W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - W'(q30_to_f(ATAN_Q30[i], FRACTION_BITS));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + W'(q30_to_f(ATAN_Q30[i], FRACTION_BITS));
            end
            neg_ff[i+1] <= neg_ff[i];
            ax_ff[i+1]  <= ax_ff[i];
            ay_ff[i+1]  <= ay_ff[i];
            az_ff[i+1]  <= az_ff[i];
         end
      end
   end

   // round a CORDIC result to Q14 and clamp to plus or minus one
   function automatic logic signed [CS_W-1:0] to_q14(input logic signed [W-1:0] v);
      logic signed [TW-1:0] e;
      logic signed [TW-1:0] r;
      e = {{(TW - W){v[W-1]}}, v};
      if (SH_R > 0) begin
         r = (e + RND) >>> SH_R;
      end else begin
         r = e <<< SH_L;
      end
      if (r > TW'(16384)) begin
         r = TW'(16384);
      end else if (r < -TW'(16384)) begin
         r = -TW'(16384);
      end
      return r[CS_W-1:0];
   endfunction

   // round Q42 to Q14 and saturate
   function automatic logic signed [ENTRY_W-1:0] finish(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      r = (v + (PW'(1) <<< 27)) >>> 28;
      if (r > PW'(32767)) begin
         r = PW'(32767);
      end else if (r < -PW'(32768)) begin
         r = -PW'(32768);
      end
      return r[ENTRY_W-1:0];
   endfunction

   // M1: sine/cosine to Q14, axis products
   logic                v1_ff;
   logic signed [15:0]  c1_ff, s1_ff, ax1_ff, ay1_ff, az1_ff;
   logic signed [31:0]  pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [W-1:0] xn, yn;

   assign xn = neg_ff[S] ? -x_ff[S] : x_ff[S];
   assign yn = neg_ff[S] ? -y_ff[S] : y_ff[S];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= cv_ff[S];
      end
      if (en) begin
         c1_ff  <= to_q14(xn);
         s1_ff  <= to_q14(yn);
         ax1_ff <= ax_ff[S];
         ay1_ff <= ay_ff[S];
         az1_ff <= az_ff[S];
         pxx_ff <= ax_ff[S] * ax_ff[S];
         pyy_ff <= ay_ff[S] * ay_ff[S];
         pzz_ff <= az_ff[S] * az_ff[S];
         pxy_ff <= ax_ff[S] * ay_ff[S];
         pxz_ff <= ax_ff[S] * az_ff[S];
         pyz_ff <= ay_ff[S] * az_ff[S];
      end
   end

   // M2: scale by (1 - c), axis times sine
   logic               v2_ff;
   logic signed [16:0] t;
   logic signed [15:0] c2_ff;
   logic signed [48:0] qxx_ff, qyy_ff, qzz_ff, qxy_ff, qxz_ff, qyz_ff;
   logic signed [31:0] kx_ff, ky_ff, kz_ff;

   assign t = 17'sd16384 - 17'(c1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         c2_ff  <= c1_ff;
         qxx_ff <= pxx_ff * t;
         qyy_ff <= pyy_ff * t;
         qzz_ff <= pzz_ff * t;
         qxy_ff <= pxy_ff * t;
         qxz_ff <= pxz_ff * t;
         qyz_ff <= pyz_ff * t;
         kx_ff  <= ax1_ff * s1_ff;
         ky_ff  <= ay1_ff * s1_ff;
         kz_ff  <= az1_ff * s1_ff;
      end
   end

   // output register: sums, rounding, saturation
   logic                       ov_ff;
   logic signed [ENTRY_W-1:0]  m_ff [9];
   logic signed [PW-1:0]       cd, sx, sy, sz;

   assign cd = PW'(c2_ff) <<< 28;
   assign sx = PW'(kx_ff) <<< 14;
   assign sy = PW'(ky_ff) <<< 14;
   assign sz = PW'(kz_ff) <<< 14;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v2_ff;
      end
      if (en) begin
         m_ff[0] <= finish(cd + PW'(qxx_ff));
         m_ff[1] <= finish(PW'(qxy_ff) - sz);
         m_ff[2] <= finish(PW'(qxz_ff) + sy);
         m_ff[3] <= finish(PW'(qxy_ff) + sz);
         m_ff[4] <= finish(cd + PW'(qyy_ff));
         m_ff[5] <= finish(PW'(qyz_ff) - sx);
         m_ff[6] <= finish(PW'(qxz_ff) - sy);
         m_ff[7] <= finish(PW'(qyz_ff) + sx);
         m_ff[8] <= finish(cd + PW'(qzz_ff));
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_m00 = m_ff[0];
   assign rsp_m01 = m_ff[1];
   assign rsp_m02 = m_ff[2];
   assign rsp_m10 = m_ff[3];
   assign rsp_m11 = m_ff[4];
   assign rsp_m12 = m_ff[5];
   assign rsp_m20 = m_ff[6];
   assign rsp_m21 = m_ff[7];
   assign rsp_m22 = m_ff[8];

endmodule

// ----- src/axis_angle_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: Rodrigues rotation matrix
// Converts an angle and a rotation axis into a 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one word per accepted cycle (req_valid high, req_stall
//   low) carrying a Q2.13 angle and a Q1.14 axis.
//   Output channel rsp_*: one word per input, nine Q1.14 entries in row-major
//   order, saturated; a word is taken when rsp_valid is high and rsp_stall low.
//   The path runs through one front stage, the queue, SINCOS_STEPS + 1 CORDIC
//   stages, two multiply stages and the output register. Throughput is one
//   word per cycle while rsp_stall is low, set by the fully pipelined CORDIC,
//   one stage per step.
//   While a word waits under rsp_stall the whole back pipeline holds; the
//   front keeps accepting until the queue between them fills, then raises
//   req_stall. Words are never dropped or reordered.
//   Reset clears all valid flags and queue pointers; no word is in flight
//   afterwards and the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix import aarm_pkg::*; #(
   parameter int SINCOS_STEPS  = SINCOS_STEPS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_angle,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22
);

   localparam int ANGLE_W = FRACTION_BITS + 4;
   localparam int WORD_W  = 1 + ANGLE_W + 3 * AXIS_W;

   q_status_type       q_status;
   logic               push, pop;
   logic [WORD_W-1:0]  push_word, pop_word;

   aarm_front #(
      .FRACTION_BITS (FRACTION_BITS),
      .ANGLE_W       (ANGLE_W),
      .WORD_W        (WORD_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_angle  (req_angle),
      .req_axis_x (req_axis_x),
      .req_axis_y (req_axis_y),
      .req_axis_z (req_axis_z),
      .q_status   (q_status),
      .push       (push),
      .push_word  (push_word)
   );

   aarm_queue #(
      .WIDTH (WORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   aarm_back #(
      .SINCOS_STEPS  (SINCOS_STEPS),
      .FRACTION_BITS (FRACTION_BITS),
      .ANGLE_W       (ANGLE_W),
      .WORD_W        (WORD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_word  (pop_word),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_m00   (rsp_m00),
      .rsp_m01   (rsp_m01),
      .rsp_m02   (rsp_m02),
      .rsp_m10   (rsp_m10),
      .rsp_m11   (rsp_m11),
      .rsp_m12   (rsp_m12),
      .rsp_m20   (rsp_m20),
      .rsp_m21   (rsp_m21),
      .rsp_m22   (rsp_m22)
   );

endmodule
